// File: src/prt_pkg.sv
// shared types and constants for the prescaled reload timer
package prt_pkg;

  localparam int CMD_W    = 3;
  localparam int DATA_W   = 8;
  localparam int CYCLES_W = 12;
  localparam int COUNT_W  = 7;

  // item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_READ_VALUE   = 3'd0,
    CMD_READ_ENABLE  = 3'd1,
    CMD_WRITE_RELOAD = 3'd2,
    CMD_WRITE_ENABLE = 3'd3,
    CMD_ADVANCE      = 3'd4
  } cmd_t;

  // open-bus merge masks
  localparam logic [DATA_W-1:0]  LATCH_TOP_MASK  = 8'h80;
  localparam logic [DATA_W-1:0]  LATCH_HIGH_MASK = 8'hFE;
  localparam logic [COUNT_W-1:0] UNDERFLOW_READ  = 7'h7F;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_cmd_t;

endpackage

// File: src/prt_if.sv
// item channel interfaces for the timer
interface prt_in_if
  import prt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [DATA_W-1:0]   write_data;
  logic [CYCLES_W-1:0] cycle_count;

  modport source (output valid, cmd, write_data, cycle_count, input ready);
  modport sink (input valid, cmd, write_data, cycle_count, output ready);
endinterface

interface prt_out_if
  import prt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              irq_pulse;

  modport source (output valid, read_data, irq_pulse, input ready);
  modport sink (input valid, read_data, irq_pulse, output ready);
endinterface

// File: src/prt_ctrl.sv
// handshake and sequencing controller for the timer
module prt_ctrl
  import prt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t cmd
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: cmd.execute = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.execute) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // the result register is only overwritten once emptied
  a_exec_free: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> (!out_valid || out_ready)) else $error("result overwritten");

  // a waiting result is kept until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

  // an accepted item always moves the controller to the execute state
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC)) else $error("item lost");

endmodule

// File: src/prt_datapath.sv
// timer state, prescaler and bus latch datapath
module prt_datapath
  import prt_pkg::*;
#(
  parameter int unsigned PRESCALE_CYCLES = 3072
) (
  input  logic                clk,
  input  logic                rst,
  input  ctl_cmd_t            cmd,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [DATA_W-1:0]   in_data,
  input  logic [CYCLES_W-1:0] in_cycles,
  output logic [DATA_W-1:0]   read_data,
  output logic                irq_pulse
);

  localparam logic [CYCLES_W-1:0] PERIOD = CYCLES_W'(PRESCALE_CYCLES);

  // captured item
  logic [CMD_W-1:0]    cmd_q;
  logic [DATA_W-1:0]   data_q;
  logic [CYCLES_W-1:0] cycles_q;

  // timer state
  logic                run_enable, run_enable_next;
  logic [COUNT_W-1:0]  reload_value, reload_value_next;
  logic [COUNT_W-1:0]  count_value, count_value_next;
  logic                underflow_flag, underflow_flag_next;
  logic [CYCLES_W-1:0] prescale_left, prescale_left_next;
  logic [DATA_W-1:0]   bus_latch, bus_latch_next;
  logic                irq_next;

  logic [CYCLES_W-1:0] rest;

  assign rest = cycles_q - prescale_left;

  always_comb begin
    run_enable_next     = run_enable;
    reload_value_next   = reload_value;
    count_value_next    = count_value;
    underflow_flag_next = underflow_flag;
    prescale_left_next  = prescale_left;
    bus_latch_next      = bus_latch;
    irq_next            = 1'b0;
    unique case (cmd_q)
      CMD_READ_VALUE: begin
        if (underflow_flag) begin
          underflow_flag_next = 1'b0;
          bus_latch_next      = (bus_latch & LATCH_TOP_MASK) | {1'b0, UNDERFLOW_READ};
        end else begin
          bus_latch_next = (bus_latch & LATCH_TOP_MASK) | {1'b0, count_value};
        end
      end
      CMD_READ_ENABLE: begin
        bus_latch_next = (bus_latch & LATCH_HIGH_MASK) | {{(DATA_W-1){1'b0}}, run_enable};
      end
      CMD_WRITE_RELOAD: begin
        bus_latch_next    = data_q;
        reload_value_next = data_q[COUNT_W-1:0];
      end
      CMD_WRITE_ENABLE: begin
        bus_latch_next = data_q;
        if (!run_enable) count_value_next = reload_value;
        run_enable_next = data_q[0];
      end
      CMD_ADVANCE: begin
        if (prescale_left < cycles_q) begin
          // period ran out: restart it from the leftover, one tick
          prescale_left_next = (rest >= PERIOD) ? '0 : PERIOD - rest;
          if (run_enable) begin
            if (count_value == '0) begin
              count_value_next    = reload_value;
              underflow_flag_next = 1'b1;
              irq_next            = 1'b1;
            end else begin
              count_value_next = count_value - COUNT_W'(1);
            end
          end
        end else begin
          prescale_left_next = prescale_left - cycles_q;
        end
      end
      default: bus_latch_next = bus_latch;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable     <= 1'b0;
      reload_value   <= '0;
      count_value    <= '0;
      underflow_flag <= 1'b0;
      prescale_left  <= PERIOD;
      bus_latch      <= '0;
    end else if (cmd.execute) begin
      run_enable     <= run_enable_next;
      reload_value   <= reload_value_next;
      count_value    <= count_value_next;
      underflow_flag <= underflow_flag_next;
      prescale_left  <= prescale_left_next;
      bus_latch      <= bus_latch_next;
    end
  end

  // item capture and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q    <= in_cmd;
      data_q   <= in_data;
      cycles_q <= in_cycles;
    end
    if (cmd.execute) begin
      read_data <= bus_latch_next;
      irq_pulse <= irq_next;
    end
  end

endmodule

// File: src/prescaled_reload_timer_regs_top.sv
// top level of the prescaled reload timer with open-bus latch
// Each input item is a bus access (read value, read enable, write reload,
// write enable) or a time advance by cycle_count cpu cycles, and each item
// gives exactly one result: the 8-bit bus latch after the access and an
// interrupt pulse flag. An accepted item is first captured, then the
// controller runs the datapath update and loads the result register. A
// result waiting at the output stalls execution of the next item only until
// it is taken, and a new item is accepted only once the last one has been
// executed. The prescaler period is set by PRESCALE_CYCLES (1 to 4095); an
// advance gives at most one tick per item.
module prescaled_reload_timer_regs_top
  import prt_pkg::*;
#(
  parameter int unsigned PRESCALE_CYCLES = 3072
) (
  input logic   clk,
  input logic   rst,
  prt_in_if.sink    in_ch,
  prt_out_if.source out_ch
);

  ctl_cmd_t ctl_cmd;

  // controller: handshakes and sequencing
  prt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (ctl_cmd)
  );

  // datapath: timer state, prescaler and latch
  prt_datapath #(
    .PRESCALE_CYCLES (PRESCALE_CYCLES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctl_cmd),
    .in_cmd    (in_ch.cmd),
    .in_data   (in_ch.write_data),
    .in_cycles (in_ch.cycle_count),
    .read_data (out_ch.read_data),
    .irq_pulse (out_ch.irq_pulse)
  );

endmodule

// File: verif/prescaled_reload_timer_regs_top_tb.sv
// testbench for the prescaled reload timer: random bus and advance items against a predictor
`timescale 1ns / 100ps

module prescaled_reload_timer_regs_top_tb;
  import prt_pkg::*;

  // prescaler period, matched between the block and the predictor
  localparam int unsigned PRESCALE     = 3072;
  localparam int          RANDOM_ITEMS = 1150;
  // generous: far more than a correct run needs
  localparam int          CYCLE_LIMIT  = 200000;
  // items at the tail of the run that go without idling on either side
  localparam int          QUIET_TAIL   = 150;
  localparam int          MAX_REPORTS  = 10;

  // one bus access or time advance
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [DATA_W-1:0]   write_data;
    logic [CYCLES_W-1:0] cycle_count;
  } timer_item_t;

  // what the bus returns for one item
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_pulse;
  } bus_result_t;

  logic clk;
  logic rst;

  prt_in_if  in_ch ();
  prt_out_if out_ch ();

  prescaled_reload_timer_regs_top #(
    .PRESCALE_CYCLES(PRESCALE)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // items still to be sent, and bus results the block still owes us
  timer_item_t pending_items[$];
  bus_result_t results_due[$];
  // accepted-item counts at which the sender holds off until the block drains
  int          drain_points[$];

  int total_items;
  int accepted_count;
  int error_count;
  int cycle_total;
  bit timed_out;

  // predictor copy of the timer state
  logic               tm_run;
  logic [COUNT_W-1:0] tm_reload;
  logic [COUNT_W-1:0] tm_count;
  logic               tm_uflow_seen;
  int unsigned        tm_prescale;
  logic [DATA_W-1:0]  tm_latch;

  // one prescaler tick; returns 1 on underflow of a running counter
  function automatic logic timer_tick();
    if (!tm_run) return 1'b0;
    if (tm_count == '0) begin
      tm_count      = tm_reload;
      tm_uflow_seen = 1'b1;
      return 1'b1;
    end
    tm_count = tm_count - 1'b1;
    return 1'b0;
  endfunction

  // apply one item to the predictor state and return the bus result it gives
  function automatic bus_result_t timer_access(timer_item_t it);
    bus_result_t r;
    int unsigned rest;
    r.irq_pulse = 1'b0;
    case (it.cmd)
      CMD_READ_VALUE: begin
        // the first read after an underflow shows all ones instead of the count
        if (tm_uflow_seen) begin
          tm_uflow_seen = 1'b0;
          tm_latch      = (tm_latch & LATCH_TOP_MASK) | {1'b0, UNDERFLOW_READ};
        end else begin
          tm_latch = (tm_latch & LATCH_TOP_MASK) | {1'b0, tm_count};
        end
      end
      CMD_READ_ENABLE: tm_latch = (tm_latch & LATCH_HIGH_MASK) | {{(DATA_W-1){1'b0}}, tm_run};
      CMD_WRITE_RELOAD: begin
        tm_latch  = it.write_data;
        tm_reload = it.write_data[COUNT_W-1:0];
      end
      CMD_WRITE_ENABLE: begin
        tm_latch = it.write_data;
        // starting a stopped timer loads the count from reload
        if (!tm_run) tm_count = tm_reload;
        tm_run = it.write_data[0];
      end
      CMD_ADVANCE: begin
        if (tm_prescale < it.cycle_count) begin
          rest        = it.cycle_count - tm_prescale;
          // leftover of a full period or more saturates at zero, still one tick
          tm_prescale = (rest >= PRESCALE) ? 0 : PRESCALE - rest;
          r.irq_pulse = timer_tick();
        end else begin
          tm_prescale = tm_prescale - it.cycle_count;
        end
      end
      default: ;  // unused codes leave everything alone
    endcase
    r.read_data = tm_latch;
    return r;
  endfunction

  task automatic queue_item(logic [CMD_W-1:0] cmd, int unsigned data, int unsigned cycles);
    timer_item_t it;
    it.cmd         = cmd;
    it.write_data  = data[DATA_W-1:0];
    it.cycle_count = cycles[CYCLES_W-1:0];
    pending_items.push_back(it);
  endtask

  // random cycle count for an advance: mostly near one period so ticks come often
  function automatic int unsigned advance_cycles();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 4095);
      1:       return $urandom_range(0, 64);
      default: return $urandom_range(2900, 3300);
    endcase
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_total <= cycle_total + 1;
  end

  // driver: presents the head of pending_items, predicts on each accepted item
  int unsigned send_gap;
  always @(posedge clk) begin
    logic        took;
    logic        next_valid;
    logic        quiet;
    timer_item_t head;
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        results_due.push_back(timer_access(pending_items.pop_front()));
        accepted_count++;
      end
      quiet      = (accepted_count + QUIET_TAIL >= total_items);
      next_valid = in_ch.valid && !took;
      // a held item stays up with its payload until it is taken
      if (!next_valid) begin
        if (drain_points.size() > 0 && accepted_count == drain_points[0]) begin
          // pause for the block to hand back everything it owes
          if (results_due.size() == 0) drain_points.pop_front();
        end
        if (pending_items.size() == 0) begin
          next_valid = 1'b0;
        end else if (drain_points.size() > 0 && accepted_count == drain_points[0]) begin
          next_valid = 1'b0;
        end else if (send_gap > 0) begin
          send_gap--;
          next_valid = 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          // start an idle burst, this one included; send_gap holds the idle cycles still to come
          send_gap   = $urandom_range(0, 2);
          next_valid = 1'b0;
        end else begin
          next_valid = 1'b1;
        end
        if (next_valid) begin
          head                 = pending_items[0];
          in_ch.cmd         <= head.cmd;
          in_ch.write_data  <= head.write_data;
          in_ch.cycle_count <= head.cycle_count;
        end
      end
      in_ch.valid <= next_valid;
    end
  end

  // monitor: checks each taken result against the oldest prediction, stalls at random
  int unsigned take_stall;
  always @(posedge clk) begin
    bus_result_t want;
    logic        quiet;
    if (rst) begin
      out_ch.ready <= 1'b0;
      take_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result: read_data=%02h irq_pulse=%0b",
                     out_ch.read_data, out_ch.irq_pulse);
        end else begin
          want = results_due.pop_front();
          if (out_ch.read_data !== want.read_data || out_ch.irq_pulse !== want.irq_pulse) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("result mismatch: read_data exp %02h got %02h, irq_pulse exp %0b got %0b",
                       want.read_data, out_ch.read_data, want.irq_pulse, out_ch.irq_pulse);
          end
        end
      end
      quiet = (accepted_count + QUIET_TAIL >= total_items);
      if (take_stall > 0) begin
        take_stall--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        take_stall = $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned n;
    int unsigned reload_byte;
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_READ_VALUE;
    in_ch.write_data   = '0;
    in_ch.cycle_count  = '0;
    out_ch.ready       = 1'b0;
    accepted_count     = 0;
    error_count        = 0;
    cycle_total        = 0;
    timed_out          = 1'b0;
    send_gap           = 0;
    take_stall         = 0;

    tm_run        = 1'b0;
    tm_reload     = '0;
    tm_count      = '0;
    tm_uflow_seen = 1'b0;
    tm_prescale   = PRESCALE;
    tm_latch      = '0;

    // directed: reads at reset, full-range writes
    queue_item(CMD_READ_VALUE, 8'hFF, 0);
    queue_item(CMD_READ_ENABLE, 8'h00, 4095);
    queue_item(CMD_WRITE_RELOAD, 8'hFF, 0);
    queue_item(CMD_WRITE_ENABLE, 8'h01, 0);       // start: count takes reload 0x7f
    queue_item(CMD_READ_VALUE, 8'h00, 0);
    queue_item(CMD_WRITE_RELOAD, 8'h00, 0);
    queue_item(CMD_WRITE_ENABLE, 8'h00, 0);       // stop while running, count kept
    queue_item(CMD_WRITE_ENABLE, 8'h01, 0);       // restart from reload zero
    // underflow at count zero, then the one-shot all-ones read
    queue_item(CMD_ADVANCE, 8'h00, PRESCALE + 1);
    queue_item(CMD_READ_VALUE, 8'h00, 0);
    queue_item(CMD_READ_VALUE, 8'h00, 0);
    // advance by zero changes nothing
    queue_item(CMD_ADVANCE, 8'hFF, 0);
    // run down to zero, then overshoot by more than a period: still a single tick, prescaler at zero
    queue_item(CMD_ADVANCE, 8'h00, 4095);
    queue_item(CMD_ADVANCE, 8'h00, 2048);
    queue_item(CMD_ADVANCE, 8'h00, 4095);
    queue_item(CMD_ADVANCE, 8'h00, 1);            // saturated prescaler ticks at once
    queue_item(CMD_READ_ENABLE, 8'h00, 0);
    queue_item(CMD_WRITE_ENABLE, 8'hFE, 0);       // stop, high latch bits set
    queue_item(CMD_READ_ENABLE, 8'h00, 0);
    queue_item(CMD_ADVANCE, 8'h00, PRESCALE);     // tick on a stopped timer
    // codes past the last command are ignored
    queue_item(CMD_W'(CMD_ADVANCE + 1), 8'hFF, 4095);
    queue_item(CMD_W'({CMD_W{1'b1}} - 1), 8'hAA, 3072);
    queue_item({CMD_W{1'b1}}, 8'h55, 4095);
    queue_item(CMD_WRITE_RELOAD, 8'h82, 0);
    queue_item(CMD_WRITE_ENABLE, 8'h03, 0);       // start from stopped loads reload 2
    drain_points.push_back(pending_items.size());

    // random: mostly reload/start runs followed by advances and reads, some noise
    while (pending_items.size() < 25 + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        reload_byte = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                    : ($urandom_range(0, 3) | ($urandom_range(0, 1) << 7));
        queue_item(CMD_WRITE_RELOAD, reload_byte, $urandom_range(0, 4095));
        if ($urandom_range(0, 2) == 0)
          queue_item(CMD_WRITE_ENABLE, $urandom_range(0, 255) & 8'hFE, $urandom_range(0, 4095));
        queue_item(CMD_WRITE_ENABLE, $urandom_range(0, 255) | 8'h01, $urandom_range(0, 4095));
        n = $urandom_range(2, 10);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0, 1:    queue_item(CMD_READ_VALUE, $urandom_range(0, 255), $urandom_range(0, 4095));
            2:       queue_item(CMD_READ_ENABLE, $urandom_range(0, 255), $urandom_range(0, 4095));
            default: queue_item(CMD_ADVANCE, $urandom_range(0, 255), advance_cycles());
          endcase
        end
      end else begin
        queue_item(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 255),
                   $urandom_range(0, 4095));
      end
      if (drain_points.size() < 2 && pending_items.size() > 600)
        drain_points.push_back(pending_items.size());
    end
    total_items = pending_items.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (!(accepted_count == total_items && results_due.size() == 0)
           && cycle_total < CYCLE_LIMIT)
      @(posedge clk);
    timed_out = (cycle_total >= CYCLE_LIMIT);

    if (timed_out) begin
      $display("CHECK FAILED");
    end else begin
      // room for any stray result to appear
      repeat (10) @(posedge clk);
      if (results_due.size() != 0) error_count++;
      if (error_count == 0)
        $display("CHECK OK");
      else
        $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/prt_pkg.sv
src/prt_if.sv
src/prt_ctrl.sv
src/prt_datapath.sv
src/prescaled_reload_timer_regs_top.sv
verif/prescaled_reload_timer_regs_top_tb.sv
